>>> rtl/slts_pkg.sv
package slts_pkg;

  localparam int unsigned MaxResults = 6;
  localparam int unsigned CountW     = $clog2(MaxResults + 1);

  localparam logic [7:0] CharSpace = 8'd32;
  localparam logic [7:0] CharTab   = 8'd9;
  localparam logic [7:0] CharNl    = 8'd10;
  localparam logic [7:0] CharSlash = 8'd47;
  localparam logic [7:0] CharUnder = 8'd95;

  // Action codes of an input item.
  localparam logic ActChar = 1'b0;
  localparam logic ActEol  = 1'b1;

  typedef struct packed {
    logic       action;
    logic [7:0] char_in;
  } in_item_t;

  typedef struct packed {
    logic [7:0] char_out;
    logic       last;
  } out_item_t;

  // All result bytes caused by one input item, packed from entry zero up.
  typedef struct packed {
    logic [MaxResults-1:0][7:0] bytes;
    logic [CountW-1:0]          count;
  } burst_t;

  function automatic logic is_word_byte(input logic [7:0] c);
    return ((c >= 8'd48) && (c <= 8'd57)) || ((c >= 8'd65) && (c <= 8'd90)) ||
           ((c >= 8'd97) && (c <= 8'd122)) || (c == CharUnder);
  endfunction

endpackage

>>> rtl/slts_core.sv
module slts_core (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              fire_i,
  input  slts_pkg::in_item_t item_i,
  output slts_pkg::burst_t  burst_o
);

  logic in_comment_q, in_comment_d;
  logic slash_held_q, slash_held_d;
  logic held_first_q, held_first_d;
  logic line_start_q, line_start_d;
  logic content_q, content_d;
  logic last_space_q, last_space_d;

  logic [slts_pkg::MaxResults-1:0][7:0] cand_b;
  logic [slts_pkg::MaxResults-1:0]      cand_v;
  logic emit_slash, emit_c, c_spaced, slash_spaced, c_is_slash;
  logic chain_cs, chain_lws;

  assign c_is_slash   = (item_i.char_in == slts_pkg::CharSlash);
  assign emit_slash   = !in_comment_q && slash_held_q &&
                        ((item_i.action == slts_pkg::ActEol) || !c_is_slash);
  assign emit_c       = (item_i.action == slts_pkg::ActChar) && !in_comment_q && !c_is_slash;
  assign slash_spaced = !held_first_q;
  assign c_spaced     = !((!slash_held_q && line_start_q) ||
                          slts_pkg::is_word_byte(item_i.char_in));

  // Candidate slots: the held slash with its spaces, then the new byte with its spaces.
  always_comb begin
    cand_b[0] = slts_pkg::CharSpace;
    cand_b[1] = slts_pkg::CharSlash;
    cand_b[2] = slts_pkg::CharSpace;
    cand_b[3] = slts_pkg::CharSpace;
    cand_b[4] = item_i.char_in;
    cand_b[5] = slts_pkg::CharSpace;
    cand_v[0] = emit_slash && slash_spaced;
    cand_v[1] = emit_slash;
    cand_v[2] = emit_slash && slash_spaced;
    cand_v[3] = emit_c && c_spaced;
    cand_v[4] = emit_c;
    cand_v[5] = emit_c && c_spaced;
  end

  // Leading strip, space collapse and the end-of-line newline, compacting the kept bytes.
  always_comb begin
    logic [slts_pkg::CountW-1:0] pos;
    logic                        keep;
    pos       = '0;
    keep      = 1'b0;
    chain_cs  = content_q;
    chain_lws = last_space_q;
    burst_o.bytes = '0;
    for (int i = 0; i < slts_pkg::MaxResults; i++) begin
      if (cand_v[i]) begin
        if (chain_cs) begin
          keep = !((cand_b[i] == slts_pkg::CharSpace) && chain_lws);
        end else begin
          keep = !((cand_b[i] == slts_pkg::CharSpace) || (cand_b[i] == slts_pkg::CharTab));
        end
        if (keep) begin
          burst_o.bytes[pos] = cand_b[i];
          pos = pos + 1'b1;
          if (chain_cs) begin
            chain_lws = (cand_b[i] == slts_pkg::CharSpace);
          end else begin
            chain_cs  = 1'b1;
            chain_lws = 1'b0;
          end
        end
      end
    end
    if ((item_i.action == slts_pkg::ActEol) && chain_cs) begin
      burst_o.bytes[pos] = slts_pkg::CharNl;
      pos = pos + 1'b1;
    end
    burst_o.count = pos;
  end

  always_comb begin
    in_comment_d = in_comment_q;
    slash_held_d = slash_held_q;
    held_first_d = held_first_q;
    line_start_d = line_start_q;
    content_d    = chain_cs;
    last_space_d = chain_lws;
    if (item_i.action == slts_pkg::ActEol) begin
      in_comment_d = 1'b0;
      slash_held_d = 1'b0;
      held_first_d = 1'b0;
      line_start_d = 1'b1;
      content_d    = 1'b0;
      last_space_d = 1'b0;
    end else if (!in_comment_q) begin
      line_start_d = 1'b0;
      if (slash_held_q) begin
        in_comment_d = c_is_slash;
        slash_held_d = 1'b0;
        held_first_d = 1'b0;
      end else if (c_is_slash) begin
        slash_held_d = 1'b1;
        held_first_d = line_start_q;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_comment_q <= 1'b0;
      slash_held_q <= 1'b0;
      held_first_q <= 1'b0;
      line_start_q <= 1'b1;
      content_q    <= 1'b0;
      last_space_q <= 1'b0;
    end else if (fire_i) begin
      in_comment_q <= in_comment_d;
      slash_held_q <= slash_held_d;
      held_first_q <= held_first_d;
      line_start_q <= line_start_d;
      content_q    <= content_d;
      last_space_q <= last_space_d;
    end
  end

`ifndef SYNTH
  a_comment_slash_excl: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(in_comment_q && slash_held_q))
    else $error("comment and held slash both set");

  a_eol_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fire_i && (item_i.action == slts_pkg::ActEol) |=>
      line_start_q && !in_comment_q && !slash_held_q && !content_q)
    else $error("end of line did not clear line state");

  a_held_first_only_held: assert property (@(posedge clk_i) disable iff (!rst_ni)
    held_first_q |-> slash_held_q)
    else $error("held slash flag without held slash");
`endif

endmodule

>>> rtl/slts_drain.sv
module slts_drain (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               load_i,
  input  slts_pkg::burst_t   burst_i,
  output logic               room_o,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output slts_pkg::out_item_t out_item_o
);

  logic [slts_pkg::MaxResults-1:0][7:0] buf_q;
  logic [slts_pkg::CountW-1:0]          cnt_q;
  logic                                 out_fire;

  assign out_fire    = out_valid_o && out_ready_i;
  assign out_valid_o = (cnt_q != '0);
  assign room_o      = (cnt_q == '0) || ((cnt_q == slts_pkg::CountW'(1)) && out_ready_i);
  assign out_item_o.char_out = buf_q[0];
  assign out_item_o.last     = (cnt_q == slts_pkg::CountW'(1));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else if (load_i) begin
      cnt_q <= burst_i.count;
    end else if (out_fire) begin
      cnt_q <= cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      buf_q <= burst_i.bytes;
    end else if (out_fire) begin
      for (int i = 0; i < slts_pkg::MaxResults - 1; i++) begin
        buf_q[i] <= buf_q[i+1];
      end
    end
  end

`ifndef SYNTH
  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= slts_pkg::CountW'(slts_pkg::MaxResults))
    else $error("result count beyond buffer depth");

  a_load_shows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    load_i && (burst_i.count != '0) |=> out_valid_o)
    else $error("loaded burst not presented");

  a_drain_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_fire && !load_i |=> cnt_q == $past(cnt_q) - 1'b1)
    else $error("drain count did not step");

  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    load_i |-> (cnt_q == '0) || ((cnt_q == slts_pkg::CountW'(1)) && out_fire))
    else $error("burst loaded over pending results");
`endif

endmodule

>>> rtl/source_line_token_spacer_top.sv
// Source line token spacer. Send one item per source byte (action 0) and one
// item with action 1 at each end of line. Every byte other than a letter,
// digit or underscore is surrounded by single spaces unless it starts its
// line, comments starting at "//" are dropped, leading blanks are stripped,
// space runs collapse to one, and a kept line ends with a newline byte (10)
// while an empty line gives nothing. A "/" is held back until the next item
// shows whether it opens a comment. Each input item yields zero to five output
// items, and the last output item of an input item carries last = 1. An input
// item is taken in the cycle after the previous one whenever that one made at
// most one output item and the output side is not stalling; an input item
// that makes N output items (N >= 2) holds the input off until its last byte
// is leaving; the result buffer drains one byte per cycle when not stalled.
module source_line_token_spacer_top (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  slts_pkg::in_item_t  in_item_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output slts_pkg::out_item_t out_item_o
);

  // The whole per-item expansion is short logic that feeds the result buffer.
  slts_pkg::burst_t burst;
  logic             in_fire;

  assign in_fire = in_valid_i && in_ready_o;

  // Line state registers and the expansion of one item into its output bytes.
  slts_core u_core (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .fire_i  (in_fire),
    .item_i  (in_item_i),
    .burst_o (burst)
  );

  // Result buffer: it is loaded when empty or while its final byte leaves.
  slts_drain u_drain (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .load_i      (in_fire),
    .burst_i     (burst),
    .room_o      (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_item_o  (out_item_o)
  );

endmodule

>>> tb/sv/source_line_token_spacer_top_test.sv
`timescale 1ns / 100ps

module source_line_token_spacer_top_test;

  localparam int unsigned ClkPeriod     = 20;
  localparam int unsigned ResetCycles   = 6;
  localparam int unsigned TotalItems    = 270;
  // The receiver holds off once for this many cycles so that the output side
  // backs up into the input handshake.
  localparam int unsigned LongHold      = 300;
  localparam int unsigned HoldAfterTake = 120;
  // A stall of LongHold plus the longest sender gap is the slowest stretch
  // in a correct run; the limit leaves a wide margin on top of that.
  localparam int unsigned WatchdogLimit = 2000;
  localparam int unsigned TailCycles    = 16;

  // The scoreboard keeps its own copy of the line state, works out the bytes
  // each accepted item should produce, and compares each output item with
  // the oldest one still waiting.
  class spacer_scoreboard;
    slts_pkg::out_item_t expected_bytes[$];
    logic [7:0]          step_bytes[$];
    int unsigned         mismatches;
    int unsigned         results_seen;
    bit                  in_cmt;
    bit                  slash_wait;
    bit                  slash_was_first;
    bit                  line_fresh;
    bit                  text_begun;
    bit                  prev_blank;

    function new();
      mismatches   = 0;
      results_seen = 0;
      clear_line();
    endfunction

    function void clear_line();
      in_cmt          = 1'b0;
      slash_wait      = 1'b0;
      slash_was_first = 1'b0;
      line_fresh      = 1'b1;
      text_begun      = 1'b0;
      prev_blank      = 1'b0;
    endfunction

    function bit is_ident_char(logic [7:0] c);
      return (c inside {[8'h30:8'h39], [8'h41:8'h5a], [8'h61:8'h7a]}) ||
             (c == slts_pkg::CharUnder);
    endfunction

    // Leading blanks of a line are stripped and space runs collapse to one.
    function void pass_byte(logic [7:0] b);
      if (!text_begun) begin
        if (b == slts_pkg::CharSpace || b == slts_pkg::CharTab) return;
        step_bytes.push_back(b);
        text_begun = 1'b1;
        prev_blank = 1'b0;
      end else begin
        if (b == slts_pkg::CharSpace && prev_blank) return;
        step_bytes.push_back(b);
        prev_blank = (b == slts_pkg::CharSpace);
      end
    endfunction

    function void spread(logic [7:0] c, bit first);
      if (first || is_ident_char(c)) begin
        pass_byte(c);
      end else begin
        pass_byte(slts_pkg::CharSpace);
        pass_byte(c);
        pass_byte(slts_pkg::CharSpace);
      end
    endfunction

    function void note_input(slts_pkg::in_item_t it);
      logic [7:0]          c;
      bit                  first;
      slts_pkg::out_item_t e;
      step_bytes.delete();
      c = it.char_in;
      if (it.action == slts_pkg::ActEol) begin
        if (slash_wait && !in_cmt) spread(slts_pkg::CharSlash, slash_was_first);
        if (text_begun) step_bytes.push_back(slts_pkg::CharNl);
        clear_line();
      end else if (!in_cmt) begin
        first      = line_fresh;
        line_fresh = 1'b0;
        if (slash_wait) begin
          slash_wait = 1'b0;
          if (c == slts_pkg::CharSlash) begin
            in_cmt          = 1'b1;
            slash_was_first = 1'b0;
          end else begin
            spread(slts_pkg::CharSlash, slash_was_first);
            slash_was_first = 1'b0;
            spread(c, 1'b0);
          end
        end else if (c == slts_pkg::CharSlash) begin
          slash_wait      = 1'b1;
          slash_was_first = first;
        end else begin
          spread(c, first);
        end
      end
      foreach (step_bytes[i]) begin
        e.char_out = step_bytes[i];
        e.last     = (i == step_bytes.size() - 1);
        expected_bytes.push_back(e);
      end
    endfunction

    function void check_result(slts_pkg::out_item_t got);
      slts_pkg::out_item_t want;
      results_seen++;
      if (expected_bytes.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("output item %0d: char_out %0d last %0b arrived with nothing expected",
                   results_seen, got.char_out, got.last);
        return;
      end
      want = expected_bytes.pop_front();
      if (got.char_out !== want.char_out || got.last !== want.last) begin
        mismatches++;
        if (mismatches <= 10)
          $display("output item %0d: char_out %0d last %0b, expected char_out %0d last %0b",
                   results_seen, got.char_out, got.last, want.char_out, want.last);
      end
    endfunction

    function int unsigned pending_count();
      return expected_bytes.size();
    endfunction
  endclass

  logic                clk_i     = 1'b0;
  logic                rst_ni    = 1'b0;
  logic                in_valid  = 1'b0;
  slts_pkg::in_item_t  in_item   = '0;
  logic                out_ready = 1'b0;
  logic                in_ready;
  logic                out_valid;
  slts_pkg::out_item_t out_item;

  spacer_scoreboard sb;
  int unsigned      burst_left   = 0;
  int unsigned      inputs_taken = 0;

  source_line_token_spacer_top dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid),
    .in_ready_o  (in_ready),
    .in_item_i   (in_item),
    .out_valid_o (out_valid),
    .out_ready_i (out_ready),
    .out_item_o  (out_item)
  );

  always #(ClkPeriod / 2) clk_i = ~clk_i;

  // Offers one item and returns at the clock edge that accepts it. The sender
  // works in bursts: when a burst runs out it may pause before the next one
  // starts. Valid is only lowered for a real gap, so it never drops and rises
  // again within one time step.
  task automatic send_item(input logic act, input logic [7:0] ch);
    int unsigned        gap;
    slts_pkg::in_item_t it;
    if (burst_left == 0) begin
      gap        = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
      burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(20, 40) : $urandom_range(1, 12);
      if (gap != 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
    end
    burst_left--;
    it.action  = act;
    it.char_in = ch;
    in_valid <= 1'b1;
    in_item  <= it;
    // Ready seen high between edges means the item goes in at the next edge.
    do @(negedge clk_i); while (!in_ready);
    @(posedge clk_i);
  endtask

  task automatic send_char(input logic [7:0] ch);
    send_item(slts_pkg::ActChar, ch);
  endtask

  // The byte that travels with an end of line is ignored by the block, so it
  // is random to exercise the field bits anyway.
  task automatic send_eol();
    send_item(slts_pkg::ActEol, 8'($urandom_range(0, 255)));
  endtask

  task automatic send_line(input string s);
    for (int i = 0; i < s.len(); i++) send_char(s[i]);
    send_eol();
  endtask

  // Source text is mostly identifiers and operators, with slashes common
  // enough to open comments and split tokens often, plus a few high bytes
  // and control bytes.
  function automatic logic [7:0] random_source_char();
    string       ops = "+-*=(){};,.<>!&|#%^~";
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 26) return 8'(97 + $urandom_range(0, 25));
    if (r < 35) return 8'(65 + $urandom_range(0, 25));
    if (r < 45) return 8'(48 + $urandom_range(0, 9));
    if (r < 50) return slts_pkg::CharUnder;
    if (r < 62) return slts_pkg::CharSpace;
    if (r < 67) return slts_pkg::CharTab;
    if (r < 77) return slts_pkg::CharSlash;
    if (r < 92) return ops[$urandom_range(0, ops.len() - 1)];
    if (r < 97) return 8'($urandom_range(128, 255));
    return ($urandom_range(0, 1) == 0) ? slts_pkg::CharNl : 8'($urandom_range(0, 31));
  endfunction

  // One random line: optional leading blanks, a body with a sprinkling of
  // fully random items, sometimes a trailing comment, then an end of line.
  task automatic random_line();
    int unsigned lead;
    int unsigned len;
    lead = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 3) : 0;
    repeat (lead) begin
      send_char(($urandom_range(0, 1) == 0) ? slts_pkg::CharSpace : slts_pkg::CharTab);
    end
    len = ($urandom_range(0, 9) == 0) ? 0 : $urandom_range(1, 14);
    repeat (len) begin
      if ($urandom_range(0, 11) == 0)
        send_item(1'($urandom_range(0, 1)), 8'($urandom_range(0, 255)));
      else
        send_char(random_source_char());
    end
    if ($urandom_range(0, 4) == 0) begin
      send_char(slts_pkg::CharSlash);
      send_char(slts_pkg::CharSlash);
      repeat ($urandom_range(0, 4)) send_char(random_source_char());
    end
    send_eol();
  endtask

  // The receiver cycles through a fully ready stretch, a mostly ready one and
  // a mostly stalled one. Once enough items have gone in, it holds off for a
  // long stretch while the sender keeps offering, which fills the block and
  // pushes back on the input.
  initial begin : receiver_proc
    int unsigned phase;
    bit          long_done;
    phase     = 0;
    long_done = 1'b0;
    forever begin
      @(posedge clk_i);
      phase++;
      if (!long_done && inputs_taken >= HoldAfterTake) begin
        long_done = 1'b1;
        out_ready <= 1'b0;
        repeat (LongHold) @(posedge clk_i);
      end else if (phase % 64 < 16) begin
        out_ready <= 1'b1;
      end else if (phase % 64 < 48) begin
        out_ready <= ($urandom_range(0, 9) < 7);
      end else begin
        out_ready <= ($urandom_range(0, 9) < 3);
      end
    end
  end

  // Both handshakes are sampled at the falling edge before the edge that completes
  // them, when every input and output has settled. The same loop watches
  // for a hang: too many cycles without any item moving ends the run.
  initial begin : monitor_proc
    int unsigned idle;
    idle = 0;
    while (idle < WatchdogLimit) begin
      @(negedge clk_i);
      idle++;
      if (in_valid && in_ready) begin
        sb.note_input(in_item);
        inputs_taken++;
        idle = 0;
      end
      if (out_valid && out_ready) begin
        sb.check_result(out_item);
        idle = 0;
      end
    end
    $display("** source_line_token_spacer_top: FAILED **");
    $finish;
  end

  initial begin : stimulus_proc
    sb = new();
    repeat (ResetCycles) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // A slash that starts its line and is only resolved by the end of line.
    send_line("/");
    // Leading blanks stripped, a held slash followed by an operator.
    send_line("\t a/+b");
    // A comment that swallows the rest of the line.
    send_line("x//c");
    // An empty line gives nothing.
    send_eol();
    // Field extremes: a zero byte first on its line, a high byte spaced as
    // an operator, and a newline byte sent as an ordinary character.
    send_char(8'h00);
    send_char(8'hff);
    send_char(slts_pkg::CharNl);
    send_eol();
    // A tab after content is spaced, and the trailing space is kept.
    send_line("y\t ");
    // A held slash at the end of a line that does not start with it.
    send_line("a/");

    while (inputs_taken < TotalItems) random_line();
    in_valid <= 1'b0;

    while (sb.pending_count() != 0) @(posedge clk_i);
    repeat (TailCycles) @(posedge clk_i);

    if (sb.mismatches == 0 && sb.pending_count() == 0) begin
      $display("** source_line_token_spacer_top: PASSED **");
    end else begin
      $display("** source_line_token_spacer_top: FAILED **");
    end
    $finish;
  end

endmodule

>>> files.f
rtl/slts_pkg.sv
rtl/slts_core.sv
rtl/slts_drain.sv
rtl/source_line_token_spacer_top.sv
tb/sv/source_line_token_spacer_top_test.sv
